// ===== design/wrm_pkg.sv =====
package wrm_pkg;

  localparam int unsigned SAMPLE_W = 16;
  // magnitude of a full-scale negative sample still fits 16 bits unsigned
  localparam int unsigned MAG_W    = 16;
  // largest square is 2^30
  localparam int unsigned SQ_W     = 31;
  localparam int unsigned RMS_W    = 15;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [MAG_W-1:0]    mag_t;
  typedef logic        [SQ_W-1:0]     square_t;
  typedef logic        [RMS_W-1:0]    rms_t;

endpackage

// ===== design/wrm_front.sv =====
module wrm_front #(
  parameter int unsigned WINDOW_LEN = 16,
  parameter int unsigned SUM_W      = 35
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  wrm_pkg::sample_t sample_i,
  output logic             q_push_o,
  input  logic             q_full_i,
  output logic [SUM_W-1:0] q_data_o
);

  localparam int unsigned CNT_W = $clog2(WINDOW_LEN);

  logic [CNT_W-1:0]   cnt_q;
  logic               sq_v_q;
  logic               sq_last_q;
  wrm_pkg::square_t   sq_q;
  logic [SUM_W-1:0]   sum_q;

  wrm_pkg::mag_t      mag;
  logic [2*wrm_pkg::MAG_W-1:0] prod;
  logic               win_end;
  logic               stall;
  logic               take;
  logic               adv;
  logic [SUM_W-1:0]   sum_next;

  assign mag      = sample_i[wrm_pkg::SAMPLE_W-1] ? wrm_pkg::mag_t'(-sample_i)
                                                  : wrm_pkg::mag_t'(sample_i);
  assign prod     = mag * mag;
  assign win_end  = (cnt_q == CNT_W'(WINDOW_LEN - 1));

  // a window's last beat waits in the square stage while the queue is full
  assign stall    = sq_v_q && sq_last_q && q_full_i;
  assign full_o   = stall;
  assign take     = push_i && !stall;
  assign adv      = sq_v_q && !stall;

  assign sum_next = sum_q + SUM_W'(sq_q);
  assign q_push_o = adv && sq_last_q;
  assign q_data_o = sum_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sq_v_q <= 1'b0;
      sum_q  <= '0;
    end else begin
      sq_v_q <= take || stall;
      if (take) begin
        cnt_q <= win_end ? '0 : cnt_q + CNT_W'(1);
      end
      if (adv) begin
        sum_q <= sq_last_q ? '0 : sum_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sq_q      <= prod[wrm_pkg::SQ_W-1:0];
      sq_last_q <= win_end;
    end
  end

endmodule

// ===== design/wrm_queue.sv =====
module wrm_queue #(
  parameter int unsigned WIDTH = 35
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  // two entries: head is read, tail refills it
  logic             head_v_q;
  logic             tail_v_q;
  logic [WIDTH-1:0] head_q;
  logic [WIDTH-1:0] tail_q;
  logic             do_pop;
  logic             do_push;

  assign full_o  = head_v_q && tail_v_q;
  assign valid_o = head_v_q;
  assign data_o  = head_q;
  assign do_pop  = pop_i && head_v_q;
  assign do_push = push_i && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      tail_v_q <= 1'b0;
    end else if (do_pop) begin
      if (tail_v_q) begin
        tail_v_q <= do_push;
      end else begin
        head_v_q <= do_push;
      end
    end else if (do_push) begin
      if (!head_v_q) begin
        head_v_q <= 1'b1;
      end else begin
        tail_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      if (tail_v_q) begin
        head_q <= tail_q;
        if (do_push) begin
          tail_q <= data_i;
        end
      end else if (do_push) begin
        head_q <= data_i;
      end
    end else if (do_push) begin
      if (!head_v_q) begin
        head_q <= data_i;
      end else begin
        tail_q <= data_i;
      end
    end
  end

endmodule

// ===== design/wrm_back.sv =====
module wrm_back #(
  parameter int unsigned WINDOW_LEN = 16,
  parameter int unsigned SUM_W      = 35
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  logic [SUM_W-1:0] q_data_i,
  output logic             q_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output wrm_pkg::rms_t    rms_o
);

  localparam int unsigned WIDE_W = SUM_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WRITE
  } state_e;

  state_e             state_q;
  logic               res_valid_q;
  wrm_pkg::rms_t      rms_q;
  logic [SUM_W-1:0]   sum_q;
  // s = N*r^2, u = 2*N*r*b, d = N*b^2 for the current root r and trial bit b
  logic [WIDE_W-1:0]  s_q;
  logic [WIDE_W-1:0]  u_q;
  logic [WIDE_W-1:0]  d_q;
  wrm_pkg::rms_t      root_q;
  wrm_pkg::rms_t      bit_q;

  logic [WIDE_W-1:0]  cand;
  logic               fits;

  // largest r with N*r^2 <= sum gives floor(sqrt(sum/N)), capped by the 15-bit search
  assign cand    = s_q + u_q + d_q;
  assign fits    = (cand <= WIDE_W'(sum_q));
  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;
  assign empty_o = !res_valid_q;
  assign rms_o   = rms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      rms_q       <= '0;
      sum_q       <= '0;
      s_q         <= '0;
      u_q         <= '0;
      d_q         <= '0;
      root_q      <= '0;
      bit_q       <= '0;
    end else begin
      if (pop_i && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            sum_q   <= q_data_i;
            s_q     <= '0;
            u_q     <= '0;
            d_q     <= WIDE_W'(WINDOW_LEN) << (2 * (wrm_pkg::RMS_W - 1));
            root_q  <= '0;
            bit_q   <= wrm_pkg::rms_t'(1) << (wrm_pkg::RMS_W - 1);
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (fits) begin
            s_q    <= cand;
            u_q    <= (u_q >> 1) + d_q;
            root_q <= root_q | bit_q;
          end else begin
            u_q <= u_q >> 1;
          end
          d_q   <= d_q >> 2;
          bit_q <= bit_q >> 1;
          if (bit_q[0]) begin
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (!res_valid_q || pop_i) begin
            rms_q       <= root_q;
            res_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/window_rms_meter_core.sv =====
// RMS meter over fixed windows of WINDOW_LEN signed 16-bit samples. A sample
// beat is taken every cycle while full_o is low; each sample is squared into a
// register stage and added into the window sum. At the end of a window the
// sum goes into a two-entry queue, and a separate square-root unit turns it
// into floor(sqrt(sum / WINDOW_LEN)), saturated to 32767, one result bit per
// cycle. A window's last sample is squared, then added into the sum and
// written into the queue; the root unit loads the sum, runs 15 root
// iterations and writes the result register, waiting there while an older
// result is not yet taken. When windows arrive faster than the root unit
// finishes them, full_o rises once the queue is full; longer windows run at
// one sample per cycle while results are taken in time. A result waits on
// rms_o while empty_o is low and is taken with pop_i, while the next window keeps accumulating.
module window_rms_meter_core #(
  parameter int unsigned WINDOW_LEN = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  wrm_pkg::sample_t sample_i,
  output logic             empty_o,
  input  logic             pop_i,
  output wrm_pkg::rms_t    rms_o
);

  localparam int unsigned SUM_W = $clog2(WINDOW_LEN) + wrm_pkg::SQ_W;

  logic             fq_push;
  logic             fq_full;
  logic [SUM_W-1:0] fq_wdata;
  logic             qb_valid;
  logic             qb_pop;
  logic [SUM_W-1:0] qb_data;

  wrm_front #(
    .WINDOW_LEN(WINDOW_LEN),
    .SUM_W     (SUM_W)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .full_o  (full_o),
    .sample_i(sample_i),
    .q_push_o(fq_push),
    .q_full_i(fq_full),
    .q_data_o(fq_wdata)
  );

  wrm_queue #(
    .WIDTH(SUM_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fq_push),
    .data_i (fq_wdata),
    .full_o (fq_full),
    .valid_o(qb_valid),
    .pop_i  (qb_pop),
    .data_o (qb_data)
  );

  wrm_back #(
    .WINDOW_LEN(WINDOW_LEN),
    .SUM_W     (SUM_W)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(qb_valid),
    .q_data_i (qb_data),
    .q_pop_o  (qb_pop),
    .empty_o  (empty_o),
    .pop_i    (pop_i),
    .rms_o    (rms_o)
  );

endmodule

// ===== design/wrm_checker.sv =====
module wrm_checker #(
  parameter int unsigned WINDOW_LEN = 16
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             push_i,
  input logic             full_o,
  input wrm_pkg::sample_t sample_i,
  input logic             empty_o,
  input logic             pop_i,
  input wrm_pkg::rms_t    rms_o
);

  localparam int unsigned CNT_W = $clog2(WINDOW_LEN);

  // sample count within the window; windows completed at the input and not yet taken at the output
  logic [CNT_W-1:0] win_cnt_q;
  logic [3:0]       pend_q;
  logic             in_beat;
  logic             out_beat;
  logic             win_done;

  assign in_beat  = push_i && !full_o;
  assign out_beat = pop_i && !empty_o;
  assign win_done = in_beat && (win_cnt_q == CNT_W'(WINDOW_LEN - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cnt_q <= '0;
      pend_q    <= '0;
    end else begin
      if (in_beat) begin
        win_cnt_q <= win_done ? '0 : win_cnt_q + CNT_W'(1);
      end
      pend_q <= pend_q + 4'(win_done) - 4'(out_beat);
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> empty_o && !full_o)
    else $error("outputs not quiet during reset");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(rms_o))
    else $error("waiting result changed or vanished");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> pend_q != 4'd0)
    else $error("result shown without a completed window");

  a_full_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> pend_q >= 4'd3)
    else $error("input stalled without a backlog of windows");

endmodule

bind window_rms_meter_core wrm_checker #(.WINDOW_LEN(WINDOW_LEN)) u_wrm_checker (.*);

// ===== test/rms_window_checker.sv =====
module rms_window_checker #(
  parameter int unsigned WINDOW_LEN = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             full_o,
  input  wrm_pkg::sample_t sample_i,
  input  logic             empty_o,
  input  logic             pop_i,
  input  wrm_pkg::rms_t    rms_o,
  output int unsigned      fails_o,
  output int unsigned      pending_o
);

  import wrm_pkg::*;

  localparam rms_t RMS_CEIL = 15'h7fff;

  logic [39:0] sq_acc;
  int unsigned taken;
  int unsigned n_fail;
  rms_t        rms_due[$];

  assign fails_o = n_fail;

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    n_fail++;
  endtask

  // floor(sqrt(acc / WINDOW_LEN)) by setting root bits from the top down
  function automatic rms_t window_rms(input logic [39:0] acc);
    logic [39:0] mean;
    logic [39:0] root;
    logic [39:0] trial;
    mean = acc / WINDOW_LEN;
    root = '0;
    for (int b = 19; b >= 0; b--) begin
      trial = root | (40'd1 << b);
      if (trial * trial <= mean) root = trial;
    end
    if (root > RMS_CEIL) return RMS_CEIL;
    return rms_t'(root);
  endfunction

  always @(posedge clk_i) begin
    logic [16:0] mag;
    rms_t        want;
    if (!rst_ni) begin
      sq_acc = '0;
      taken  = 0;
      rms_due.delete();
    end else begin
      // a result beat can never belong to the sample taken on the same edge
      if (pop_i && !empty_o) begin
        if (rms_due.size() == 0) begin
          flag_mismatch($sformatf("result beat rms=%0d with nothing expected", rms_o));
        end else begin
          want = rms_due.pop_front();
          if (rms_o !== want)
            flag_mismatch($sformatf("rms got %0d want %0d", rms_o, want));
        end
      end
      if (push_i && !full_o) begin
        mag = sample_i[15] ? (17'h10000 - {1'b0, sample_i}) : {1'b0, sample_i};
        sq_acc = sq_acc + 40'(mag) * 40'(mag);
        taken++;
        if (taken == WINDOW_LEN) begin
          rms_due.push_back(window_rms(sq_acc));
          sq_acc = '0;
          taken  = 0;
        end
      end
    end
    pending_o <= rms_due.size();
  end

endmodule

// ===== test/tb.sv =====
module tb;

  import wrm_pkg::*;

  localparam int unsigned WINDOW_LEN = 16;
  localparam int unsigned N_RANDOM_WINDOWS = 32;

  typedef enum int unsigned {
    WIN_UNIFORM,
    WIN_QUIET,
    WIN_LOUD,
    WIN_FLAT,
    WIN_ZERO,
    WIN_FULL_NEG
  } window_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push_i;
  logic        full_o;
  sample_t     sample_i;
  logic        empty_o;
  logic        pop_i;
  rms_t        rms_o;
  int unsigned mismatches;
  int unsigned rms_owed;

  logic [15:0] corner_vals [16] = '{
    16'h7fff, 16'h8000, 16'h0000, 16'h0001, 16'hffff, 16'h8001, 16'h5555, 16'haaaa,
    16'h00ff, 16'hff00, 16'h0f0f, 16'hf0f0, 16'h7ffe, 16'h4000, 16'hc000, 16'h0002
  };

  always #6 clk_i = ~clk_i;

  window_rms_meter_core #(.WINDOW_LEN(WINDOW_LEN)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .full_o  (full_o),
    .sample_i(sample_i),
    .empty_o (empty_o),
    .pop_i   (pop_i),
    .rms_o   (rms_o)
  );

  rms_window_checker #(.WINDOW_LEN(WINDOW_LEN)) u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .full_o   (full_o),
    .sample_i (sample_i),
    .empty_o  (empty_o),
    .pop_i    (pop_i),
    .rms_o    (rms_o),
    .fails_o  (mismatches),
    .pending_o(rms_owed)
  );

  // mostly back to back, sometimes a short gap, rarely a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic sample_t pick_sample(input window_kind_e kind, input sample_t level);
    int unsigned mag;
    case (kind)
      WIN_QUIET: begin
        return sample_t'(int'($urandom_range(255)) - 128);
      end
      WIN_LOUD: begin
        mag = $urandom_range(32768, 32000);
        if ($urandom_range(1) == 1) return sample_t'(-int'(mag));
        return sample_t'(mag > 32767 ? 32767 : mag);
      end
      WIN_FLAT:     return level;
      WIN_ZERO:     return '0;
      WIN_FULL_NEG: return sample_t'(16'h8000);
      default:      return sample_t'($urandom_range(16'hffff));
    endcase
  endfunction

  task automatic put_sample(input sample_t s, input bit steady);
    int unsigned gap;
    push_i   <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (full_o);
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      push_i   <= 1'b0;
      sample_i <= sample_t'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic put_window(input window_kind_e kind);
    sample_t level;
    bit      steady;
    level  = sample_t'($urandom);
    steady = ($urandom_range(3) == 0);
    for (int i = 0; i < WINDOW_LEN; i++) put_sample(pick_sample(kind, level), steady);
  endtask

  // result side: random stalls with calm stretches where pop stays high
  initial begin
    int unsigned gap;
    int unsigned stretch;
    bit          calm;
    stretch = 0;
    calm    = 1'b0;
    forever begin
      if (stretch == 0) begin
        calm    = ($urandom_range(4) == 0);
        stretch = $urandom_range(60, 10);
      end
      stretch--;
      gap = calm ? 0 : idle_len();
      if (gap == 0) begin
        pop_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        pop_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    window_kind_e kind;
    int unsigned  r;
    rst_ni   <= 1'b0;
    push_i   <= 1'b0;
    sample_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-scale negative saturates, silence gives zero, then assorted corners
    put_window(WIN_FULL_NEG);
    put_window(WIN_ZERO);
    for (int i = 0; i < WINDOW_LEN; i++) put_sample(sample_t'(corner_vals[i]), 1'b0);

    for (int w = 0; w < N_RANDOM_WINDOWS; w++) begin
      r = $urandom_range(99);
      if (r < 40)      kind = WIN_UNIFORM;
      else if (r < 55) kind = WIN_QUIET;
      else if (r < 75) kind = WIN_LOUD;
      else if (r < 88) kind = WIN_FLAT;
      else if (r < 94) kind = WIN_ZERO;
      else             kind = WIN_FULL_NEG;
      put_window(kind);
    end
    push_i <= 1'b0;

    @(posedge clk_i);
    while (rms_owed != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
